// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the refractive index block, used by its top level.
// Clocked on clk, disabled while arst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GRII_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define GRII_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hw/rtl/grii_pkg.sv -----
// Package for the refractive index interpolator: widths, table and item types.
// Used by every module of the block; depends on nothing.
package grii_pkg;

	localparam int IN_W          = 16;
	localparam int OUT_W         = 48;
	localparam int IDX_W         = 6;
	localparam int STEP_SHIFT    = 10;
	localparam int STEP_Q12      = 1024;
	localparam int ENTRY_W       = 23;
	localparam int SLOPE_W       = 17;
	localparam int SCALED_W      = 34;
	localparam int PROD_W        = SCALED_W + IN_W;
	localparam int UNIT_SHIFT    = 19;
	localparam int FIVE_POW_W    = 21;
	localparam int DIV_W         = FIVE_POW_W + IN_W;
	localparam int GIVEN_POINTS  = 20;
	localparam int GIVEN_IDX_W   = 5;

	localparam int DEF_TABLE_POINTS         = 20;
	localparam int DEF_RESULT_FRACTION_BITS = 40;

	localparam logic [IN_W-1:0]       TREF_RESET = 16'd18762;
	localparam logic [FIVE_POW_W-1:0] FIVE_POW9  = 21'd1953125;

	localparam logic [ENTRY_W-1:0] GIVEN_EXCESS [GIVEN_POINTS] = '{
		23'd68528,   23'd137070,  23'd205626,  23'd274196,  23'd342781,
		23'd411379,  23'd479992,  23'd548618,  23'd617259,  23'd685914,
		23'd754583,  23'd823266,  23'd891964,  23'd960675,  23'd1029400,
		23'd1098140, 23'd1166894, 23'd1235662, 23'd1304444, 23'd1373240
	};

	localparam logic [ENTRY_W-1:0] LAST_ENTRY = GIVEN_EXCESS[GIVEN_POINTS-1];
	localparam logic [ENTRY_W-1:0] LAST_SLOPE =
		GIVEN_EXCESS[GIVEN_POINTS-1] - GIVEN_EXCESS[GIVEN_POINTS-2];

	typedef struct packed {
		logic               sat;
		logic               zero;
		logic [DIV_W-1:0]   rem;
		logic [OUT_W-1:0]   work;
		logic [DIV_W-1:0]   divisor;
	} grii_div_t;

	typedef struct packed {
		logic [OUT_W-1:0] index_excess;
		logic             saturated;
		logic             zero_temperature;
	} grii_res_t;

	// n-1 at table point k in units of 1e-9; past the given points extend the last segment
	function automatic logic [ENTRY_W-1:0] table_entry(input logic [IDX_W-1:0] k);
		logic [IDX_W-1:0] ext;
		ext = k - IDX_W'(GIVEN_POINTS - 1);
		if (k < IDX_W'(GIVEN_POINTS)) begin
			return GIVEN_EXCESS[k[GIVEN_IDX_W-1:0]];
		end
		return LAST_ENTRY + ENTRY_W'(ext) * LAST_SLOPE;
	endfunction

endpackage

// ----- hw/rtl/grii_front.sv -----
// Front pipeline: table lookup, interpolation, temperature scaling and overflow check.
// Depends on grii_pkg; feeds the first divider cell.
module grii_front #(
	parameter int TABLE_POINTS         = grii_pkg::DEF_TABLE_POINTS,
	parameter int RESULT_FRACTION_BITS = grii_pkg::DEF_RESULT_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [grii_pkg::IN_W-1:0]     pressure,
	input  logic [grii_pkg::IN_W-1:0]     temperature_k,
	input  logic [grii_pkg::IN_W-1:0]     reference_temperature,
	output logic                          head_valid,
	output grii_pkg::grii_div_t           head_item
);

	localparam int X_W   = grii_pkg::IN_W + 1;
	localparam int SHIFT = RESULT_FRACTION_BITS - grii_pkg::UNIT_SHIFT;
	localparam int NW    = grii_pkg::PROD_W + SHIFT;
	localparam int HI_W  = NW - grii_pkg::OUT_W;
	localparam logic [X_W-1:0] LAST_X = X_W'(TABLE_POINTS * grii_pkg::STEP_Q12);
	localparam logic [grii_pkg::IDX_W-1:0] LAST_IDX = grii_pkg::IDX_W'(TABLE_POINTS - 1);

	logic                              below;
	logic                              above;
	logic [grii_pkg::IDX_W-1:0]        idx;
	logic [grii_pkg::ENTRY_W-1:0]      y0;
	logic [grii_pkg::ENTRY_W-1:0]      y1;
	logic [grii_pkg::IN_W-1:0]         frac;

	logic                              valid_s1;
	logic                              zero_s1;
	logic [grii_pkg::ENTRY_W-1:0]      y0_s1;
	logic [grii_pkg::SLOPE_W-1:0]      slope_s1;
	logic [grii_pkg::IN_W-1:0]         frac_s1;
	logic [grii_pkg::IN_W-1:0]         temp_s1;

	logic                              valid_s2;
	logic                              zero_s2;
	logic [grii_pkg::SCALED_W-1:0]     scaled_s2;
	logic [grii_pkg::DIV_W-1:0]        div_s2;

	logic                              valid_s3;
	logic                              zero_s3;
	logic [grii_pkg::PROD_W-1:0]       prod_s3;
	logic [grii_pkg::DIV_W-1:0]        div_s3;

	logic [NW-1:0]                     num;
	logic [HI_W-1:0]                   num_hi;
	logic                              ovf;

	logic                              valid_s4;
	grii_pkg::grii_div_t               item_s4;

	always_comb begin
		below = pressure <= grii_pkg::IN_W'(grii_pkg::STEP_Q12);
		above = {1'b0, pressure} >= LAST_X;
		idx   = above ? LAST_IDX : pressure[grii_pkg::IN_W-1:grii_pkg::STEP_SHIFT];
		y1    = grii_pkg::table_entry(idx);
		y0    = below ? grii_pkg::table_entry('0) : grii_pkg::table_entry(idx - 1'b1);
		frac  = below ? '0 : pressure - {idx, {grii_pkg::STEP_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		num    = {{(NW - grii_pkg::PROD_W){1'b0}}, prod_s3} << SHIFT;
		num_hi = num[NW-1:grii_pkg::OUT_W];
		ovf    = grii_pkg::DIV_W'(num_hi) >= div_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1   <= temperature_k == '0;
			y0_s1     <= y0;
			slope_s1  <= grii_pkg::SLOPE_W'(y1 - y0);
			frac_s1   <= frac;
			temp_s1   <= temperature_k;

			zero_s2   <= zero_s1;
			scaled_s2 <= {{(grii_pkg::SCALED_W - grii_pkg::ENTRY_W - grii_pkg::STEP_SHIFT){1'b0}},
				y0_s1, {grii_pkg::STEP_SHIFT{1'b0}}}
				+ grii_pkg::SCALED_W'(frac_s1 * slope_s1);
			div_s2    <= temp_s1 * grii_pkg::FIVE_POW9;

			zero_s3   <= zero_s2;
			prod_s3   <= scaled_s2 * reference_temperature;
			div_s3    <= div_s2;

			item_s4.sat     <= ovf;
			item_s4.zero    <= zero_s3;
			item_s4.rem     <= grii_pkg::DIV_W'(num_hi);
			item_s4.work    <= num[grii_pkg::OUT_W-1:0];
			item_s4.divisor <= div_s3;
		end
	end

	assign head_valid = valid_s4;
	assign head_item  = item_s4;

endmodule

// ----- hw/rtl/grii_div_cell.sv -----
// One restoring-division cell: produces one quotient bit and passes the item on.
// Depends on grii_pkg; chained in the top level.
module grii_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  grii_pkg::grii_div_t  in_item,
	output logic                 out_valid,
	output grii_pkg::grii_div_t  out_item
);

	logic [grii_pkg::DIV_W:0]   shifted;
	logic [grii_pkg::DIV_W:0]   diff;
	logic                       ge;
	grii_pkg::grii_div_t        next_item;

	logic                       valid_s1;
	grii_pkg::grii_div_t        item_s1;

	always_comb begin
		shifted   = {in_item.rem, in_item.work[grii_pkg::OUT_W-1]};
		diff      = shifted - {1'b0, in_item.divisor};
		ge        = shifted >= {1'b0, in_item.divisor};
		next_item = in_item;
		next_item.rem  = ge ? diff[grii_pkg::DIV_W-1:0] : shifted[grii_pkg::DIV_W-1:0];
		next_item.work = {in_item.work[grii_pkg::OUT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= next_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// ----- hw/rtl/grii_out_fifo.sv -----
// Two-entry output buffer that decouples the pipeline from receiver stalls.
// Depends on grii_pkg.
module grii_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  grii_pkg::grii_res_t  push_item,
	input  logic                 stall,
	output logic                 pop_valid,
	output grii_pkg::grii_res_t  pop_item,
	output logic                 room
);

	localparam int DEPTH = 2;

	logic [1:0]             count_q;
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	grii_pkg::grii_res_t    mem_q [DEPTH];
	logic                   pop;

	assign pop       = (count_q != '0) && !stall;
	assign pop_valid = count_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];
	assign room      = count_q != 2'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hw/rtl/gas_refractive_index_interp_core.sv -----
// Top level of the gas refractive index interpolator.
// Depends on grii_pkg, grii_front, grii_div_cell, grii_out_fifo and assert_macros.svh.
//
// Usage:
//   Input channel in_valid / in_stall carries pressure (Q4.12 atm) and
//   temperature_k (Q10.6 K). Output channel out_valid / out_stall carries
//   index_excess (n-1, unsigned, RESULT_FRACTION_BITS fraction bits),
//   saturated and zero_temperature. An item moves when valid is high and
//   stall is low at a rising edge.
//   cfg_wr_en / cfg_wr_data write reference_temperature; write it only while
//   no item is in flight.
//   From input acceptance to output an item passes four front stages,
//   one division cell per result bit (48), and the output buffer.
//   Throughput: one item per cycle while the output buffer has room,
//   set by the fully pipelined cell chain. When the receiver stalls, the
//   two-entry output buffer absorbs in-flight items; once it is full the
//   whole pipeline holds and in_stall rises.
//   Reset empties the pipeline and buffer and sets reference_temperature to
//   293.15 K.
`include "assert_macros.svh"
module gas_refractive_index_interp_core #(
	parameter int TABLE_POINTS         = grii_pkg::DEF_TABLE_POINTS,
	parameter int RESULT_FRACTION_BITS = grii_pkg::DEF_RESULT_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [grii_pkg::IN_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [grii_pkg::IN_W-1:0]     pressure,
	input  logic [grii_pkg::IN_W-1:0]     temperature_k,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [grii_pkg::OUT_W-1:0]    index_excess,
	output logic                          saturated,
	output logic                          zero_temperature
);

	localparam int CELLS = grii_pkg::OUT_W;

	logic [grii_pkg::IN_W-1:0]  reference_temperature_q;
	logic                       room;
	logic [CELLS:0]             chain_valid;
	grii_pkg::grii_div_t        chain_item [CELLS+1];
	grii_pkg::grii_res_t        tail_res;
	grii_pkg::grii_res_t        out_res;
	logic                       push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_temperature_q <= grii_pkg::TREF_RESET;
		end else if (cfg_wr_en) begin
			reference_temperature_q <= cfg_wr_data;
		end
	end

	assign in_stall = !room;

	grii_front #(
		.TABLE_POINTS         (TABLE_POINTS),
		.RESULT_FRACTION_BITS (RESULT_FRACTION_BITS)
	) u_front (
		.clk                   (clk),
		.arst_n                (arst_n),
		.en                    (room),
		.in_valid              (in_valid),
		.pressure              (pressure),
		.temperature_k         (temperature_k),
		.reference_temperature (reference_temperature_q),
		.head_valid            (chain_valid[0]),
		.head_item             (chain_item[0])
	);

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		grii_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (room),
			.in_valid  (chain_valid[g]),
			.in_item   (chain_item[g]),
			.out_valid (chain_valid[g+1]),
			.out_item  (chain_item[g+1])
		);
	end

	always_comb begin
		tail_res.index_excess     = chain_item[CELLS].sat ? '1 : chain_item[CELLS].work;
		tail_res.saturated        = chain_item[CELLS].sat;
		tail_res.zero_temperature = chain_item[CELLS].zero;
	end

	assign push = chain_valid[CELLS] && room;

	grii_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (tail_res),
		.stall     (out_stall),
		.pop_valid (out_valid),
		.pop_item  (out_res),
		.room      (room)
	);

	assign index_excess     = out_res.index_excess;
	assign saturated        = out_res.saturated;
	assign zero_temperature = out_res.zero_temperature;

	`GRII_ASSERT_IMP(a_zero_temp_saturates, out_valid && zero_temperature, saturated && (&index_excess))
	`GRII_ASSERT_IMP(a_head_zero_flags_sat, chain_valid[0] && chain_item[0].zero, chain_item[0].sat)
	`GRII_ASSERT_NXT(a_full_holds_tail, !room, chain_valid[CELLS] == $past(chain_valid[CELLS]))

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for gas_refractive_index_interp_core: directed table, then random items.
// Expected n-1 values come from an exact rational predictor kept in this file.
// Depends on grii_pkg and the RTL of the block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEP            = 1024;
	localparam int POINTS          = grii_pkg::DEF_TABLE_POINTS;
	localparam int FRAC_BITS       = grii_pkg::DEF_RESULT_FRACTION_BITS;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int SETTLE_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT  = 4000;

	localparam logic [63:0] EXCESS_PPB [20] = '{
		64'd68528,   64'd137070,  64'd205626,  64'd274196,  64'd342781,
		64'd411379,  64'd479992,  64'd548618,  64'd617259,  64'd685914,
		64'd754583,  64'd823266,  64'd891964,  64'd960675,  64'd1029400,
		64'd1098140, 64'd1166894, 64'd1235662, 64'd1304444, 64'd1373240
	};

	localparam grii_pkg::grii_res_t ZERO_T_RESULT =
		'{index_excess: '1, saturated: 1'b1, zero_temperature: 1'b1};
	localparam grii_pkg::grii_res_t CLAMPED_RESULT =
		'{index_excess: '1, saturated: 1'b1, zero_temperature: 1'b0};

	typedef struct {
		logic [15:0]         tref;
		logic [15:0]         pressure;
		logic [15:0]         temperature;
		bit                  typed;
		grii_pkg::grii_res_t result;
	} probe_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] pressure;
	logic [15:0] temperature_k;
	logic        out_valid;
	logic        out_stall;
	logic [47:0] index_excess;
	logic        saturated;
	logic        zero_temperature;

	grii_pkg::grii_res_t index_q [$];
	logic [15:0]         tref_now = grii_pkg::TREF_RESET;
	int                  errors = 0;
	int                  quiet_cycles = 0;
	int unsigned         no_gap_run = 0;

	probe_row_t probes [23] = '{
		'{16'd18762, 16'd0,     16'd18762, 1'b0, '0},
		'{16'd18762, 16'd1024,  16'd18762, 1'b0, '0},
		'{16'd18762, 16'd1025,  16'd18762, 1'b0, '0},
		'{16'd18762, 16'd2047,  16'd18762, 1'b0, '0},
		'{16'd18762, 16'd2048,  16'd18762, 1'b0, '0},
		'{16'd18762, 16'd20479, 16'd18762, 1'b0, '0},
		'{16'd18762, 16'd20480, 16'd18762, 1'b0, '0},
		'{16'd18762, 16'd20481, 16'd18762, 1'b0, '0},
		'{16'd18762, 16'd65535, 16'd18762, 1'b0, '0},
		'{16'd18762, 16'd0,     16'd0,     1'b1, ZERO_T_RESULT},
		'{16'd18762, 16'd65535, 16'd0,     1'b1, ZERO_T_RESULT},
		'{16'd18762, 16'd0,     16'd1,     1'b0, '0},
		'{16'd18762, 16'd65535, 16'd1,     1'b0, '0},
		'{16'd18762, 16'd0,     16'd65535, 1'b0, '0},
		'{16'd18762, 16'd65535, 16'd65535, 1'b0, '0},
		'{16'd18762, 16'hAAAA,  16'h5555,  1'b0, '0},
		'{16'd18762, 16'h5555,  16'hAAAA,  1'b0, '0},
		'{16'd65535, 16'd65535, 16'd1,     1'b1, CLAMPED_RESULT},
		'{16'd65535, 16'd0,     16'd1,     1'b0, '0},
		'{16'd65535, 16'd65535, 16'd65535, 1'b0, '0},
		'{16'd1,     16'd0,     16'd65535, 1'b0, '0},
		'{16'd1,     16'd65535, 16'd1,     1'b0, '0},
		'{16'd1,     16'd20480, 16'd0,     1'b1, ZERO_T_RESULT}
	};

	gas_refractive_index_interp_core #(
		.TABLE_POINTS(POINTS),
		.RESULT_FRACTION_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pressure(pressure),
		.temperature_k(temperature_k),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.index_excess(index_excess),
		.saturated(saturated),
		.zero_temperature(zero_temperature)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [127:0] excess_at(input int unsigned k);
		if (k < 20) begin
			return 128'(EXCESS_PPB[k]);
		end
		return 128'(EXCESS_PPB[19]) + 128'(k - 19) * 128'(EXCESS_PPB[19] - EXCESS_PPB[18]);
	endfunction

	function automatic grii_pkg::grii_res_t predict_index(input logic [15:0] p, t, tref);
		logic [127:0]        scaled;
		logic [127:0]        quo;
		int unsigned         seg;
		grii_pkg::grii_res_t r;
		r = CLAMPED_RESULT;
		if (t == 16'd0) begin
			return ZERO_T_RESULT;
		end
		if (int'(p) <= STEP) begin
			scaled = excess_at(0) * 128'(STEP);
		end else begin
			seg = (int'(p) >= POINTS * STEP) ? POINTS - 1 : int'(p) >> 10;
			scaled = excess_at(seg - 1) * 128'(STEP)
				+ 128'(int'(p) - int'(seg) * STEP) * (excess_at(seg) - excess_at(seg - 1));
		end
		quo = ((scaled * 128'(tref)) << FRAC_BITS)
			/ (128'(STEP) * 128'd1000000000 * 128'(t));
		if (quo <= 128'hFFFF_FFFF_FFFF) begin
			r.index_excess = quo[47:0];
			r.saturated = 1'b0;
		end
		return r;
	endfunction

	// most gaps short, a few long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void pick_item(output logic [15:0] p, output logic [15:0] t);
		int unsigned kind;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			p = 16'($urandom_range(1, 21) * STEP + $urandom_range(0, 2) - 1);
		end else if (kind < 25) begin
			p = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		end else if (kind < 65) begin
			p = 16'($urandom_range(0, (POINTS + 1) * STEP));
		end else begin
			p = 16'($urandom);
		end
		kind = $urandom_range(0, 99);
		if (kind < 4) begin
			t = 16'd0;
		end else if (kind < 15) begin
			t = 16'($urandom_range(1, 64));
		end else if (kind < 65) begin
			t = 16'($urandom_range(12800, 25600));
		end else begin
			t = 16'($urandom);
		end
	endfunction

	task automatic send_item(input logic [15:0] p, input logic [15:0] t, input bit typed,
			input grii_pkg::grii_res_t typed_res);
		int unsigned gap;
		if (no_gap_run != 0) begin
			no_gap_run--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 31) == 0) begin
				no_gap_run = $urandom_range(20, 80);
			end
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pressure <= p;
		temperature_k <= t;
		do @(posedge clk); while (in_stall);
		index_q.push_back(typed ? typed_res : predict_index(p, t, tref_now));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (index_q.size() != 0);
	endtask

	task automatic set_reference(input logic [15:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tref_now = v;
	endtask

	initial begin : stimulus
		logic [15:0] p;
		logic [15:0] t;
		int unsigned pause_at;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		pressure <= '0;
		temperature_k <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (probes[k]) begin
			if (probes[k].tref != tref_now) begin
				set_reference(probes[k].tref);
			end
			send_item(probes[k].pressure, probes[k].temperature, probes[k].typed,
				probes[k].result);
		end
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_reference(16'd18762);
				1: set_reference(16'd65535);
				2: set_reference(16'd1);
				default: set_reference(16'($urandom_range(1, 65535)));
			endcase
			pause_at = $urandom_range(20, ITEMS_PER_PHASE - 20);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == pause_at) begin
					drain_results();
				end
				pick_item(p, t);
				send_item(p, t, 1'b0, '0);
			end
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	initial begin : receiver
		int unsigned hold;
		forever begin
			if ($urandom_range(0, 9) < 2) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(50, 300)) @(posedge clk);
			end else begin
				hold = idle_len();
				if (hold != 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_result
		grii_pkg::grii_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (index_q.size() == 0) begin
				$display("%0t: result with nothing expected: index_excess %h", $time, index_excess);
				errors++;
			end else begin
				want = index_q.pop_front();
				if (index_excess !== want.index_excess) begin
					$display("%0t: index_excess expected %h got %h", $time,
						want.index_excess, index_excess);
					errors++;
				end
				if (saturated !== want.saturated) begin
					$display("%0t: saturated expected %b got %b", $time,
						want.saturated, saturated);
					errors++;
				end
				if (zero_temperature !== want.zero_temperature) begin
					$display("%0t: zero_temperature expected %b got %b", $time,
						want.zero_temperature, zero_temperature);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("testbench: FAIL");
			$finish;
		end
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/grii_pkg.sv
hw/rtl/grii_front.sv
hw/rtl/grii_div_cell.sv
hw/rtl/grii_out_fifo.sv
hw/rtl/gas_refractive_index_interp_core.sv
test/testbench.sv
